>>> rtl/core/aabb_frustum_cull_macros.svh
// ----------------------------------------------------------------------------
// aabb_frustum_cull assertion macros
// Shared concurrent assertion forms for the frustum culling block.
// ----------------------------------------------------------------------------
`ifndef AABB_FRUSTUM_CULL_MACROS_SVH
`define AABB_FRUSTUM_CULL_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/afc_pkg.sv
// ----------------------------------------------------------------------------
// afc_pkg
// Types and constants shared by the frustum culling block.
// ----------------------------------------------------------------------------
package afc_pkg;

  localparam int AFC_NUM_PLANES = 6;
  localparam int AFC_COORD_W    = 16;
  localparam int AFC_CFG_IDX_W  = 8;
  localparam int AFC_CFG_DATA_W = 64;
  localparam int AFC_PROD_W     = 32;
  // Three products of up to 2^30 plus d scaled by 2^14 stay below 2^32.
  localparam int AFC_SUM_W      = 34;
  localparam int AFC_D_SHIFT    = 14;
  localparam int AFC_IN_DATA_W  = 96;
  localparam int AFC_OUT_DATA_W = 8;

  // Box corners, min_x in the lowest bits.
  typedef struct packed {
    logic signed [AFC_COORD_W-1:0] max_z;
    logic signed [AFC_COORD_W-1:0] max_y;
    logic signed [AFC_COORD_W-1:0] max_x;
    logic signed [AFC_COORD_W-1:0] min_z;
    logic signed [AFC_COORD_W-1:0] min_y;
    logic signed [AFC_COORD_W-1:0] min_x;
  } box_t;

  // Packed plane register, a in the lowest bits.
  typedef struct packed {
    logic signed [AFC_COORD_W-1:0] d;
    logic signed [AFC_COORD_W-1:0] c;
    logic signed [AFC_COORD_W-1:0] b;
    logic signed [AFC_COORD_W-1:0] a;
  } plane_t;

  // Load enables of the lane stages.
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } adv_t;

endpackage

>>> rtl/core/afc_plane_regs.sv
// ----------------------------------------------------------------------------
// afc_plane_regs
// Holds the frustum plane registers written through the configuration port.
// ----------------------------------------------------------------------------
module afc_plane_regs
  import afc_pkg::*;
#(
  parameter int NUM_PLANES = AFC_NUM_PLANES
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  input  logic [AFC_CFG_IDX_W-1:0]  cfg_index,
  input  logic [AFC_CFG_DATA_W-1:0] cfg_data,
  output plane_t                    planes [NUM_PLANES]
);

  plane_t planes_r [NUM_PLANES];

  // Writes to an index beyond the last plane match no register and are dropped.
  always_ff @(posedge clk) begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      if (!rst_n) begin
        planes_r[p] <= '0;
      end else if (cfg_valid && (cfg_index == AFC_CFG_IDX_W'(p))) begin
        planes_r[p] <= plane_t'(cfg_data);
      end
    end
  end

  assign planes = planes_r;

endmodule

>>> rtl/core/afc_plane_lane.sv
// ----------------------------------------------------------------------------
// afc_plane_lane
// Three-stage test of one box against one plane: corner select, multiply, sum.
// ----------------------------------------------------------------------------
module afc_plane_lane
  import afc_pkg::*;
(
  input  logic   clk,
  input  adv_t   adv,
  input  plane_t plane,
  input  box_t   box,
  output logic   pass
);

  // The corner farthest along the normal gives the largest distance, and the
  // axes are independent, so each axis picks the coordinate whose product
  // with the normal component is larger.
  function automatic logic signed [AFC_COORD_W-1:0] pick_axis(
    input logic signed [AFC_COORD_W-1:0] coef,
    input logic signed [AFC_COORD_W-1:0] lo,
    input logic signed [AFC_COORD_W-1:0] hi
  );
    logic signed [AFC_COORD_W-1:0] big;
    logic signed [AFC_COORD_W-1:0] sml;
    big = (hi > lo) ? hi : lo;
    sml = (hi > lo) ? lo : hi;
    return coef[AFC_COORD_W-1] ? sml : big;
  endfunction

  logic signed [AFC_COORD_W-1:0] sel_x_r, sel_y_r, sel_z_r;
  logic signed [AFC_COORD_W-1:0] sel_x_nxt, sel_y_nxt, sel_z_nxt;
  logic signed [AFC_PROD_W-1:0]  prod_x_r, prod_y_r, prod_z_r;
  logic signed [AFC_PROD_W-1:0]  prod_x_nxt, prod_y_nxt, prod_z_nxt;
  logic signed [AFC_SUM_W-1:0]   d_ext;
  logic signed [AFC_SUM_W-1:0]   sum_nxt;
  logic                          pass_r;
  logic                          pass_nxt;

  always_comb begin
    sel_x_nxt = pick_axis(plane.a, box.min_x, box.max_x);
    sel_y_nxt = pick_axis(plane.b, box.min_y, box.max_y);
    sel_z_nxt = pick_axis(plane.c, box.min_z, box.max_z);
  end

  assign prod_x_nxt = sel_x_r * plane.a;
  assign prod_y_nxt = sel_y_r * plane.b;
  assign prod_z_nxt = sel_z_r * plane.c;

  assign d_ext    = {{(AFC_SUM_W-AFC_COORD_W-AFC_D_SHIFT){plane.d[AFC_COORD_W-1]}},
                     plane.d, {AFC_D_SHIFT{1'b0}}};
  assign sum_nxt  = AFC_SUM_W'(prod_x_r) + AFC_SUM_W'(prod_y_r) + AFC_SUM_W'(prod_z_r)
                    + d_ext;
  assign pass_nxt = !sum_nxt[AFC_SUM_W-1] && (sum_nxt != '0);

  always_ff @(posedge clk) begin
    if (adv.en1) begin
      sel_x_r <= sel_x_nxt;
      sel_y_r <= sel_y_nxt;
      sel_z_r <= sel_z_nxt;
    end
    if (adv.en2) begin
      prod_x_r <= prod_x_nxt;
      prod_y_r <= prod_y_nxt;
      prod_z_r <= prod_z_nxt;
    end
    if (adv.en3) begin
      pass_r <= pass_nxt;
    end
  end

  assign pass = pass_r;

endmodule

>>> rtl/core/aabb_frustum_cull.sv
// ----------------------------------------------------------------------------
// aabb_frustum_cull
// Axis-aligned box versus frustum visibility test, one box per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Contents
// in_       slave      in_tvalid/in_tready    box min and max corners, Q12.4
// out_      master     out_tvalid/out_tready  visible flag
// cfg_      slave      cfg_valid/cfg_ready    plane register index and value
//
// A box passes from input transaction to output transaction through corner
// select, multiply, sum and sign, then the AND over all planes into the output
// register. A new box enters every cycle while the output is not stalled; the
// rate is set by one multiplier per axis and plane in the multiply stage. Reset
// clears every plane to zero, so every box reads as not visible until planes
// are written. A stall at the output backs up stage by stage; empty stages
// still fill, and nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "aabb_frustum_cull_macros.svh"

module aabb_frustum_cull
  import afc_pkg::*;
#(
  parameter int NUM_PLANES = AFC_NUM_PLANES
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // Input box transaction.
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // Fields from bit 0 up: min_x, min_y, min_z, max_x, max_y, max_z (16 bits each).
  input  logic [AFC_IN_DATA_W-1:0]  in_tdata,
  // Result transaction.
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // Fields from bit 0 up: visible (1 bit), then zero padding.
  output logic [AFC_OUT_DATA_W-1:0] out_tdata,
  // Plane register writes; index i selects plane i.
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [AFC_CFG_IDX_W-1:0]  cfg_index,
  input  logic [AFC_CFG_DATA_W-1:0] cfg_data
);

  plane_t                planes [NUM_PLANES];
  box_t                  box;
  adv_t                  adv;
  logic [NUM_PLANES-1:0] pass_w;

  // Valid bits that travel alongside the lane stages.
  logic s1_vld_r, s2_vld_r, s3_vld_r, out_vld_r;
  logic visible_r;
  logic rdy1, rdy2, rdy3, rdy_out;

  // Plane registers are always ready to take a write.
  assign cfg_ready = 1'b1;

  afc_plane_regs #(
    .NUM_PLANES (NUM_PLANES)
  ) u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .planes    (planes)
  );

  // Each stage loads when it is empty or when its content moves on, so a
  // bubble anywhere in the pipeline is squeezed out during a stall.
  assign rdy_out   = !out_vld_r || out_tready;
  assign rdy3      = !s3_vld_r || rdy_out;
  assign rdy2      = !s2_vld_r || rdy3;
  assign rdy1      = !s1_vld_r || rdy2;
  assign in_tready = rdy1;

  assign adv.en1 = rdy1;
  assign adv.en2 = rdy2;
  assign adv.en3 = rdy3;

  assign box = box_t'(in_tdata);

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_lane
    afc_plane_lane u_lane (
      .clk   (clk),
      .adv   (adv),
      .plane (planes[p]),
      .box   (box),
      .pass  (pass_w[p])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_vld_r <= in_tvalid;
      end
      if (rdy2) begin
        s2_vld_r <= s1_vld_r;
      end
      if (rdy3) begin
        s3_vld_r <= s2_vld_r;
      end
      if (rdy_out) begin
        out_vld_r <= s3_vld_r;
      end
    end
  end

  // The box is visible only when it lies partly in front of every plane.
  always_ff @(posedge clk) begin
    if (rdy_out) begin
      visible_r <= &pass_w;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(AFC_OUT_DATA_W-1){1'b0}}, visible_r};

  `AFC_ASSERT_NXT(a_in_fills_s1, clk, rst_n, in_tvalid && in_tready, s1_vld_r, "accepted box did not reach stage one")
  `AFC_ASSERT_IMP(a_empty_s1_ready, clk, rst_n, !s1_vld_r, in_tready, "input stalled with empty first stage")
  `AFC_ASSERT_NXT(a_s3_hold, clk, rst_n, s3_vld_r && !rdy3, $stable(pass_w), "stalled plane results changed")
  `AFC_ASSERT_NXT(a_vis_and, clk, rst_n, s3_vld_r && rdy_out, out_tvalid && (visible_r == &$past(pass_w)), "visible flag is not the AND of plane results")

endmodule
